### rtl/joint_impedance_torque_loop_defines.svh
`ifndef JOINT_IMPEDANCE_TORQUE_LOOP_DEFINES_SVH
`define JOINT_IMPEDANCE_TORQUE_LOOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JITL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jitl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define JITL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jitl assertion failed");

`endif

### rtl/jitl_pkg.sv
package jitl_pkg;

  localparam int JOINTS_DEF = 7;
  localparam int JOINT_W    = 3;
  localparam int DATA_W     = 24;
  localparam int LANE_W     = 9;
  localparam int LANES_W    = 63;
  localparam int STEP_W     = 21;
  localparam int FGAIN_W    = 17;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 6;
  localparam int PROD_W     = 43;
  localparam int ACC_W      = 44;

  localparam logic [LANES_W-1:0] PROP_RST  = 63'd724104011789168800;
  localparam logic [LANES_W-1:0] DAMP_RST  = 63'd578719170703753344;
  localparam logic [LANES_W-1:0] LIMIT_RST = 63'd216595830912364119;
  localparam logic [STEP_W-1:0]  STEP_RST  = 21'd1049;
  localparam logic [FGAIN_W-1:0] FGAIN_RST = 17'd25290;
  localparam logic [FGAIN_W-1:0] FGAIN_ONE = 17'd65536;

  typedef enum logic [2:0] {
    REG_PROP  = 3'd0,
    REG_DAMP  = 3'd1,
    REG_LIMIT = 3'd2,
    REG_STEP  = 3'd3,
    REG_FGAIN = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LANES_W-1:0] prop;
    logic [LANES_W-1:0] damp;
    logic [LANES_W-1:0] limit;
    logic [STEP_W-1:0]  step;
    logic [FGAIN_W-1:0] fgain;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_STEP,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_D,
    OP_RAW,
    OP_MUL_G,
    OP_MUL_H,
    OP_FILT,
    OP_OUT,
    OP_OUT_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   commit;
  } dp_cmd_t;

  typedef struct packed {
    logic joint_ok;
  } dp_stat_t;

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(25'sd8388607));
    lo = -ACC_W'(signed'(25'sd8388608));
    if (x > hi) begin
      return 24'sh7FFFFF;
    end else if (x < lo) begin
      return 24'sh800000;
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

### rtl/jitl_in_if.sv
interface jitl_in_if;
  logic                                valid;
  logic                                ready;
  logic [jitl_pkg::JOINT_W-1:0]        joint;
  logic signed [jitl_pkg::DATA_W-1:0]  goal_angle;
  logic signed [jitl_pkg::DATA_W-1:0]  measured_angle;
  logic signed [jitl_pkg::DATA_W-1:0]  measured_velocity;
  logic signed [jitl_pkg::DATA_W-1:0]  feedforward_torque;
  logic                                restart;

  modport source (
    output valid, joint, goal_angle, measured_angle, measured_velocity,
           feedforward_torque, restart,
    input  ready
  );
  modport sink (
    input  valid, joint, goal_angle, measured_angle, measured_velocity,
           feedforward_torque, restart,
    output ready
  );
endinterface

### rtl/jitl_out_if.sv
interface jitl_out_if;
  logic                                valid;
  logic                                ready;
  logic [jitl_pkg::JOINT_W-1:0]        joint_out;
  logic signed [jitl_pkg::DATA_W-1:0]  torque_command;
  logic signed [jitl_pkg::DATA_W-1:0]  interp_angle_out;

  modport source (
    output valid, joint_out, torque_command, interp_angle_out,
    input  ready
  );
  modport sink (
    input  valid, joint_out, torque_command, interp_angle_out,
    output ready
  );
endinterface

### rtl/jitl_regs.sv
module jitl_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jitl_pkg::CFG_AW-1:0]   paddr,
  input  logic [jitl_pkg::CFG_DW-1:0]   pwdata,
  output logic [jitl_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output jitl_pkg::cfg_t                cfg
);

  jitl_pkg::cfg_t     cfg_r;
  jitl_pkg::reg_idx_t idx;

  assign idx    = jitl_pkg::reg_idx_t'(paddr[jitl_pkg::CFG_AW-1:3]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop  <= jitl_pkg::PROP_RST;
      cfg_r.damp  <= jitl_pkg::DAMP_RST;
      cfg_r.limit <= jitl_pkg::LIMIT_RST;
      cfg_r.step  <= jitl_pkg::STEP_RST;
      cfg_r.fgain <= jitl_pkg::FGAIN_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        jitl_pkg::REG_PROP:  cfg_r.prop  <= pwdata[jitl_pkg::LANES_W-1:0];
        jitl_pkg::REG_DAMP:  cfg_r.damp  <= pwdata[jitl_pkg::LANES_W-1:0];
        jitl_pkg::REG_LIMIT: cfg_r.limit <= pwdata[jitl_pkg::LANES_W-1:0];
        jitl_pkg::REG_STEP:  cfg_r.step  <= pwdata[jitl_pkg::STEP_W-1:0];
        jitl_pkg::REG_FGAIN: cfg_r.fgain <= pwdata[jitl_pkg::FGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jitl_pkg::REG_PROP:  prdata = {1'b0, cfg_r.prop};
      jitl_pkg::REG_DAMP:  prdata = {1'b0, cfg_r.damp};
      jitl_pkg::REG_LIMIT: prdata = {1'b0, cfg_r.limit};
      jitl_pkg::REG_STEP:  prdata = {43'b0, cfg_r.step};
      jitl_pkg::REG_FGAIN: prdata = {47'b0, cfg_r.fgain};
      default:             prdata = '0;
    endcase
  end

endmodule

### rtl/jitl_ctrl.sv
`include "joint_impedance_torque_loop_defines.svh"

module jitl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  jitl_pkg::dp_stat_t stat,
  output jitl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_ERR,
    S_MUL_P,
    S_MUL_D,
    S_RAW,
    S_MUL_G,
    S_MUL_H,
    S_FILT,
    S_OUT,
    S_ZERO
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = jitl_pkg::OP_IDLE;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = jitl_pkg::OP_LOAD;
          state_nxt = stat.joint_ok ? S_STEP : S_ZERO;
        end
      end
      S_STEP: begin
        cmd.op    = jitl_pkg::OP_STEP;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op    = jitl_pkg::OP_ERR;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op    = jitl_pkg::OP_MUL_P;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op    = jitl_pkg::OP_MUL_D;
        state_nxt = S_RAW;
      end
      S_RAW: begin
        cmd.op    = jitl_pkg::OP_RAW;
        state_nxt = S_MUL_G;
      end
      S_MUL_G: begin
        cmd.op    = jitl_pkg::OP_MUL_G;
        state_nxt = S_MUL_H;
      end
      S_MUL_H: begin
        cmd.op    = jitl_pkg::OP_MUL_H;
        state_nxt = S_FILT;
      end
      S_FILT: begin
        cmd.op    = jitl_pkg::OP_FILT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op        = jitl_pkg::OP_OUT;
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.op        = jitl_pkg::OP_OUT_ZERO;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `JITL_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, state_r != S_IDLE)
  `JITL_ASSERT_NEXT(a_result_held, out_valid_r && !out_ready, out_valid_r)
  `JITL_ASSERT_NEXT(a_bad_joint_no_math, in_valid && in_ready && !stat.joint_ok, state_r == S_ZERO)

endmodule

### rtl/jitl_dp.sv
module jitl_dp #(
  parameter int JOINTS = jitl_pkg::JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  jitl_pkg::cfg_t                     cfg,
  input  jitl_pkg::dp_cmd_t                  cmd,
  output jitl_pkg::dp_stat_t                 stat,
  input  logic [jitl_pkg::JOINT_W-1:0]       in_joint,
  input  logic signed [jitl_pkg::DATA_W-1:0] in_goal_angle,
  input  logic signed [jitl_pkg::DATA_W-1:0] in_measured_angle,
  input  logic signed [jitl_pkg::DATA_W-1:0] in_measured_velocity,
  input  logic signed [jitl_pkg::DATA_W-1:0] in_feedforward_torque,
  input  logic                               in_restart,
  output logic [jitl_pkg::JOINT_W-1:0]       out_joint_out,
  output logic signed [jitl_pkg::DATA_W-1:0] out_torque_command,
  output logic signed [jitl_pkg::DATA_W-1:0] out_interp_angle_out
);

  localparam int DW = jitl_pkg::DATA_W;
  localparam int AW = jitl_pkg::ACC_W;
  localparam int PW = jitl_pkg::PROD_W;
  localparam int GW = jitl_pkg::FGAIN_W;
  localparam int LW = jitl_pkg::LANE_W;
  localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [jitl_pkg::JOINT_W:0] JOINTS_L = (jitl_pkg::JOINT_W + 1)'(JOINTS);

  logic [jitl_pkg::JOINT_W-1:0] joint_r;
  logic signed [DW-1:0]         goal_r, meas_r, vel_r, ff_r;
  logic                         restart_r;
  logic signed [DW-1:0]         interp_r, old_r, raw_r, filt_r;
  logic signed [DW:0]           err_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [AW-1:0]         acc_r;
  logic signed [DW-1:0]         ia_r [JOINTS];
  logic signed [DW-1:0]         ft_r [JOINTS];
  logic [jitl_pkg::JOINT_W-1:0] oj_r;
  logic signed [DW-1:0]         ot_r, oa_r;

  logic [IW-1:0]        idx;
  logic [LW-1:0]        kp, kd, lim9;
  logic [GW-1:0]        g_eff, h_eff, mul_a;
  logic signed [DW:0]   mul_b;
  logic signed [DW-1:0] base;
  logic signed [DW:0]   d_raw, d_clip, step_s;
  logic signed [DW+1:0] sum_s;
  logic signed [DW:0]   lim_s, filt_s, cmd_s;

  assign stat.joint_ok = {1'b0, in_joint} < JOINTS_L;

  assign idx  = joint_r[IW-1:0];
  assign kp   = cfg.prop[LW*joint_r +: LW];
  assign kd   = cfg.damp[LW*joint_r +: LW];
  assign lim9 = cfg.limit[LW*joint_r +: LW];

  assign g_eff = (cfg.fgain > jitl_pkg::FGAIN_ONE) ? jitl_pkg::FGAIN_ONE : cfg.fgain;
  assign h_eff = GW'(jitl_pkg::FGAIN_ONE - g_eff);

  // interpolation step, clipped to +-step limit
  always_comb begin
    base   = restart_r ? meas_r : ia_r[idx];
    step_s = signed'({4'b0, cfg.step});
    d_raw  = (DW+1)'(goal_r) - (DW+1)'(base);
    if (d_raw > step_s) begin
      d_clip = step_s;
    end else if (d_raw < -step_s) begin
      d_clip = -step_s;
    end else begin
      d_clip = d_raw;
    end
    sum_s = (DW+2)'(base) + (DW+2)'(d_clip);
  end

  always_comb begin
    case (cmd.op)
      jitl_pkg::OP_MUL_P: begin
        mul_a = {8'b0, kp};
        mul_b = err_r;
      end
      jitl_pkg::OP_MUL_D: begin
        mul_a = {8'b0, kd};
        mul_b = (DW+1)'(vel_r);
      end
      jitl_pkg::OP_MUL_G: begin
        mul_a = g_eff;
        mul_b = (DW+1)'(raw_r);
      end
      default: begin
        mul_a = h_eff;
        mul_b = (DW+1)'(old_r);
      end
    endcase
  end

  // clamp filtered torque to +-limit
  always_comb begin
    lim_s  = signed'({1'b0, lim9, 15'b0});
    filt_s = (DW+1)'(filt_r);
    if (filt_s > lim_s) begin
      cmd_s = lim_s;
    end else if (filt_s < -lim_s) begin
      cmd_s = -lim_s;
    end else begin
      cmd_s = filt_s;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      jitl_pkg::OP_LOAD: begin
        joint_r   <= in_joint;
        goal_r    <= in_goal_angle;
        meas_r    <= in_measured_angle;
        vel_r     <= in_measured_velocity;
        ff_r      <= in_feedforward_torque;
        restart_r <= in_restart;
      end
      jitl_pkg::OP_STEP: begin
        interp_r <= jitl_pkg::sat24(AW'(sum_s));
        old_r    <= restart_r ? '0 : ft_r[idx];
      end
      jitl_pkg::OP_ERR: begin
        err_r <= (DW+1)'(interp_r) - (DW+1)'(meas_r);
      end
      jitl_pkg::OP_MUL_P, jitl_pkg::OP_MUL_G: begin
        prod_r <= signed'({1'b0, mul_a}) * mul_b;
      end
      jitl_pkg::OP_MUL_D: begin
        acc_r  <= (AW'(prod_r) <<< 2) + (AW'(ff_r) <<< 9);
        prod_r <= signed'({1'b0, mul_a}) * mul_b;
      end
      jitl_pkg::OP_RAW: begin
        raw_r <= jitl_pkg::sat24((acc_r - AW'(prod_r) + AW'(256)) >>> 9);
      end
      jitl_pkg::OP_MUL_H: begin
        acc_r  <= AW'(prod_r) + AW'(32768);
        prod_r <= signed'({1'b0, mul_a}) * mul_b;
      end
      jitl_pkg::OP_FILT: begin
        filt_r <= jitl_pkg::sat24((acc_r + AW'(prod_r)) >>> 16);
      end
      jitl_pkg::OP_OUT: begin
        oj_r <= joint_r;
        ot_r <= cmd_s[DW-1:0];
        oa_r <= interp_r;
      end
      jitl_pkg::OP_OUT_ZERO: begin
        oj_r <= joint_r;
        ot_r <= '0;
        oa_r <= '0;
      end
      default: ;
    endcase
  end

  // per-joint state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINTS; j++) begin
        ia_r[j] <= '0;
        ft_r[j] <= '0;
      end
    end else if (cmd.commit) begin
      ia_r[idx] <= interp_r;
      ft_r[idx] <= filt_r;
    end
  end

  assign out_joint_out        = oj_r;
  assign out_torque_command   = ot_r;
  assign out_interp_angle_out = oa_r;

endmodule

### rtl/joint_impedance_torque_loop.sv
// Joint impedance torque loop.
// in_ch carries one joint sample per request: joint index, goal angle, measured
// angle and velocity, feedforward torque and a restart flag. out_ch returns one
// result per request: the joint, the clamped low-pass torque command and the
// updated interpolated angle. Samples for a joint outside 0..JOINTS-1 return
// zeros and leave all state alone.
// Gains, limits, step limit and filter gain are written over the APB port at
// byte address 8*i; write them only while the block is idle.
// Timing: in_ch.ready is high only while idle. One request is in work at a time:
// a sample is loaded, goes through the eight compute steps around the single
// shared 18x25 multiplier (four products) and then the output store, which raises
// out_ch.valid; an out-of-range joint goes from the load straight to a zero store.
// A new sample is taken only after the store of the last one.
// The result waits in an output register; the next sample is taken and worked
// on meanwhile, and only its final store waits for out_ch.ready.
// Reset (synchronous, active low) loads the default register values and clears
// the interpolated angle and filtered torque of every joint.
module joint_impedance_torque_loop #(
  parameter int JOINTS = jitl_pkg::JOINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  jitl_in_if.sink                     in_ch,
  jitl_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jitl_pkg::CFG_AW-1:0] paddr,
  input  logic [jitl_pkg::CFG_DW-1:0] pwdata,
  output logic [jitl_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  jitl_pkg::cfg_t     cfg;
  jitl_pkg::dp_cmd_t  cmd;
  jitl_pkg::dp_stat_t stat;

  jitl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jitl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jitl_dp #(
    .JOINTS (JOINTS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_joint              (in_ch.joint),
    .in_goal_angle         (in_ch.goal_angle),
    .in_measured_angle     (in_ch.measured_angle),
    .in_measured_velocity  (in_ch.measured_velocity),
    .in_feedforward_torque (in_ch.feedforward_torque),
    .in_restart            (in_ch.restart),
    .out_joint_out         (out_ch.joint_out),
    .out_torque_command    (out_ch.torque_command),
    .out_interp_angle_out  (out_ch.interp_angle_out)
  );

endmodule

### verif/joint_impedance_torque_loop_tb.sv
module joint_impedance_torque_loop_tb;

  localparam int NJ             = jitl_pkg::JOINTS_DEF;
  localparam int A_MAX          = 8388607;
  localparam int A_MIN          = -8388608;
  localparam int MAX_GAP        = 18;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 238;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef struct {
    logic [jitl_pkg::JOINT_W-1:0]       joint;
    logic signed [jitl_pkg::DATA_W-1:0] goal;
    logic signed [jitl_pkg::DATA_W-1:0] meas;
    logic signed [jitl_pkg::DATA_W-1:0] vel;
    logic signed [jitl_pkg::DATA_W-1:0] ff;
    logic                               restart;
  } joint_sample_t;

  typedef struct {
    logic [jitl_pkg::JOINT_W-1:0]       joint;
    logic signed [jitl_pkg::DATA_W-1:0] torque;
    logic signed [jitl_pkg::DATA_W-1:0] interp;
  } torque_cmd_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [jitl_pkg::CFG_AW-1:0] paddr;
  logic [jitl_pkg::CFG_DW-1:0] pwdata;
  logic [jitl_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  jitl_in_if  in_ch();
  jitl_out_if out_ch();

  joint_impedance_torque_loop uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file
  logic [jitl_pkg::LANES_W-1:0] kp_lanes;
  logic [jitl_pkg::LANES_W-1:0] kd_lanes;
  logic [jitl_pkg::LANES_W-1:0] lim_lanes;
  logic [jitl_pkg::STEP_W-1:0]  step_lim;
  logic [jitl_pkg::FGAIN_W-1:0] lp_gain;

  // per-joint loop state
  longint interp_track [NJ];
  longint torque_lp    [NJ];
  int     traj         [NJ];

  joint_sample_t samples_to_send[$];
  torque_cmd_t   torque_cmd_due[$];
  joint_sample_t sample_on_bus;
  torque_cmd_t   exp_cmd;

  int   send_gap;
  int   recv_stall;
  int   idle_cycles;
  int   mismatches;
  int   results_seen;
  bit   quiet_send;
  bit   quiet_recv;
  logic nxt_valid;
  logic nxt_ready;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clip24(longint x);
    if (x > A_MAX) return A_MAX;
    if (x < A_MIN) return A_MIN;
    return x;
  endfunction

  function automatic torque_cmd_t predict_command(joint_sample_t s);
    torque_cmd_t r;
    int     k;
    longint meas, step, d, ang, kp, kd, lim, acc, raw, g, filt, cmd;
    r.joint  = s.joint;
    r.torque = '0;
    r.interp = '0;
    if (s.joint >= NJ) return r;
    k    = s.joint;
    meas = s.meas;
    if (s.restart) begin
      interp_track[k] = meas;
      torque_lp[k]    = 0;
    end
    step = step_lim;
    d    = longint'(s.goal) - interp_track[k];
    if (d > step) d = step;
    if (d < -step) d = -step;
    ang = clip24(interp_track[k] + d);
    interp_track[k] = ang;
    kp  = (kp_lanes >> (jitl_pkg::LANE_W * k)) & 9'h1FF;
    kd  = (kd_lanes >> (jitl_pkg::LANE_W * k)) & 9'h1FF;
    lim = (lim_lanes >> (jitl_pkg::LANE_W * k)) & 9'h1FF;
    acc = kp * (ang - meas) * 4 - kd * longint'(s.vel) + longint'(s.ff) * 512;
    raw = clip24((acc + 256) >>> 9);
    g   = lp_gain;
    if (g > 65536) g = 65536;
    filt = clip24((g * raw + (65536 - g) * torque_lp[k] + 32768) >>> 16);
    torque_lp[k] = filt;
    lim = lim * 32768;
    cmd = filt;
    if (cmd > lim) cmd = lim;
    if (cmd < -lim) cmd = -lim;
    r.torque = jitl_pkg::DATA_W'(cmd);
    r.interp = jitl_pkg::DATA_W'(ang);
    return r;
  endfunction

  // mostly smooth per-joint trajectories, some raw noise
  function automatic joint_sample_t random_sample();
    joint_sample_t s;
    int unsigned   pick;
    int            j, spread, noise;
    pick    = $urandom_range(0, 99);
    j       = $urandom_range(0, NJ - 1);
    s.joint = jitl_pkg::JOINT_W'(j);
    if (pick < 18) begin
      s.joint   = jitl_pkg::JOINT_W'($urandom_range(0, 7));
      s.goal    = jitl_pkg::DATA_W'($urandom);
      s.meas    = jitl_pkg::DATA_W'($urandom);
      s.vel     = jitl_pkg::DATA_W'($urandom);
      s.ff      = jitl_pkg::DATA_W'($urandom);
      s.restart = 1'($urandom_range(0, 1));
      return s;
    end
    s.restart = (pick < 27);
    spread    = 1 << $urandom_range(2, 17);
    traj[j]   = traj[j] + int'($urandom_range(0, 2 * spread)) - spread;
    if (traj[j] > 4000000 || traj[j] < -4000000) traj[j] = 0;
    s.goal = jitl_pkg::DATA_W'(traj[j]);
    noise  = 1 << $urandom_range(2, 14);
    s.meas = jitl_pkg::DATA_W'(traj[j] + int'($urandom_range(0, 2 * noise)) - noise);
    noise  = 1 << $urandom_range(2, 20);
    s.vel  = jitl_pkg::DATA_W'(int'($urandom_range(0, 2 * noise)) - noise);
    noise  = 1 << $urandom_range(2, 20);
    s.ff   = jitl_pkg::DATA_W'(int'($urandom_range(0, 2 * noise)) - noise);
    return s;
  endfunction

  function automatic logic [jitl_pkg::CFG_DW-1:0] random_lanes();
    logic [jitl_pkg::CFG_DW-1:0] v;
    v = {$urandom, $urandom};
    for (int j = 0; j < NJ; j++) begin
      case ($urandom_range(0, 5))
        0: v[jitl_pkg::LANE_W*j +: jitl_pkg::LANE_W] = '0;
        1: v[jitl_pkg::LANE_W*j +: jitl_pkg::LANE_W] = '1;
        2: v[jitl_pkg::LANE_W*j +: jitl_pkg::LANE_W] =
             jitl_pkg::LANE_W'($urandom_range(0, 60));
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic push_sample(input int j, input int goal, input int meas, input int vel,
                             input int ff, input bit restart);
    joint_sample_t s;
    s.joint   = jitl_pkg::JOINT_W'(j);
    s.goal    = jitl_pkg::DATA_W'(goal);
    s.meas    = jitl_pkg::DATA_W'(meas);
    s.vel     = jitl_pkg::DATA_W'(vel);
    s.ff      = jitl_pkg::DATA_W'(ff);
    s.restart = restart;
    samples_to_send.push_back(s);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [jitl_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= jitl_pkg::CFG_AW'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      jitl_pkg::REG_PROP:  kp_lanes  = val[jitl_pkg::LANES_W-1:0];
      jitl_pkg::REG_DAMP:  kd_lanes  = val[jitl_pkg::LANES_W-1:0];
      jitl_pkg::REG_LIMIT: lim_lanes = val[jitl_pkg::LANES_W-1:0];
      jitl_pkg::REG_STEP:  step_lim  = val[jitl_pkg::STEP_W-1:0];
      jitl_pkg::REG_FGAIN: lp_gain   = val[jitl_pkg::FGAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_ch.valid || torque_cmd_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        torque_cmd_due.push_back(predict_command(sample_on_bus));
        nxt_valid = 1'b0;
        send_gap  = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!nxt_valid && samples_to_send.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          sample_on_bus = samples_to_send.pop_front();
          in_ch.joint              <= sample_on_bus.joint;
          in_ch.goal_angle         <= sample_on_bus.goal;
          in_ch.measured_angle     <= sample_on_bus.meas;
          in_ch.measured_velocity  <= sample_on_bus.vel;
          in_ch.feedforward_torque <= sample_on_bus.ff;
          in_ch.restart            <= sample_on_bus.restart;
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      nxt_ready = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (torque_cmd_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: joint %0d torque %0d angle %0d", results_seen,
                     out_ch.joint_out, out_ch.torque_command, out_ch.interp_angle_out);
        end else begin
          exp_cmd = torque_cmd_due.pop_front();
          if (out_ch.joint_out !== exp_cmd.joint || out_ch.torque_command !== exp_cmd.torque ||
              out_ch.interp_angle_out !== exp_cmd.interp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp joint %0d torque %0d angle %0d, got %0d %0d %0d",
                       results_seen, exp_cmd.joint, exp_cmd.torque, exp_cmd.interp,
                       out_ch.joint_out, out_ch.torque_command, out_ch.interp_angle_out);
          end
        end
        nxt_ready  = 1'b0;
        recv_stall = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!nxt_ready) begin
        if (recv_stall > 0) begin
          if (out_ch.valid) recv_stall--;
        end else begin
          nxt_ready = 1'b1;
        end
      end
      out_ch.ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("joint_impedance_torque_loop: mismatch");
      $finish;
    end
  end

  initial begin
    logic [jitl_pkg::CFG_DW-1:0] alt_lim;
    logic [jitl_pkg::CFG_DW-1:0] v;

    rst_n                    = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    in_ch.valid              = 1'b0;
    in_ch.joint              = '0;
    in_ch.goal_angle         = '0;
    in_ch.measured_angle     = '0;
    in_ch.measured_velocity  = '0;
    in_ch.feedforward_torque = '0;
    in_ch.restart            = 1'b0;
    out_ch.ready             = 1'b0;
    quiet_send               = 1'b0;
    quiet_recv               = 1'b0;
    mismatches               = 0;
    results_seen             = 0;
    idle_cycles              = 0;
    kp_lanes                 = jitl_pkg::PROP_RST;
    kd_lanes                 = jitl_pkg::DAMP_RST;
    lim_lanes                = jitl_pkg::LIMIT_RST;
    step_lim                 = jitl_pkg::STEP_RST;
    lp_gain                  = jitl_pkg::FGAIN_RST;
    for (int j = 0; j < NJ; j++) begin
      interp_track[j] = 0;
      torque_lp[j]    = 0;
      traj[j]         = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: extremes, saturation, limits, bad joint
    push_sample(0, 0, 0, 0, 0, 1);
    push_sample(0, A_MAX, A_MIN, 0, 0, 1);
    push_sample(1, A_MIN, 0, 0, 0, 0);
    push_sample(2, 1000, 500, 0, 0, 1);
    push_sample(3, 0, 0, A_MAX, A_MIN, 1);
    push_sample(3, 0, 0, A_MIN, A_MAX, 0);
    push_sample(4, 0, 0, 0, A_MAX, 0);
    push_sample(4, 0, 0, 0, A_MAX, 0);
    push_sample(6, 0, 0, 0, A_MIN, 0);
    push_sample(6, 0, 0, 0, A_MIN, 0);
    push_sample(7, A_MAX, A_MIN, A_MAX, A_MIN, 1);
    push_sample(5, A_MIN, A_MAX, 0, 0, 1);
    push_sample(5, A_MIN, A_MAX, -1, 1, 0);
    wait_idle();

    // full gains, alternating zero limits, oversized step and gain
    alt_lim = '0;
    for (int j = 0; j < NJ; j += 2) alt_lim[jitl_pkg::LANE_W*j +: jitl_pkg::LANE_W] = '1;
    reg_write(jitl_pkg::REG_PROP, '1);
    reg_write(jitl_pkg::REG_DAMP, '1);
    reg_write(jitl_pkg::REG_LIMIT, alt_lim);
    reg_write(jitl_pkg::REG_STEP, '1);
    reg_write(jitl_pkg::REG_FGAIN, '1);
    reg_write(REG_SPARE, '1);
    push_sample(0, A_MAX, A_MIN, 0, 0, 1);
    push_sample(0, A_MAX, A_MIN, A_MIN, A_MAX, 0);
    push_sample(1, A_MIN, A_MAX, A_MAX, A_MIN, 1);
    push_sample(2, A_MIN, A_MAX, 0, 0, 1);
    push_sample(3, 12345, -12345, 777, -999, 1);
    push_sample(7, 0, 0, 0, 0, 0);
    push_sample(6, A_MAX, A_MAX, 0, A_MAX, 1);
    wait_idle();

    // frozen interpolation, frozen filter, zero limits
    reg_write(jitl_pkg::REG_LIMIT, '0);
    reg_write(jitl_pkg::REG_STEP, '0);
    reg_write(jitl_pkg::REG_FGAIN, '0);
    push_sample(4, A_MAX, 0, 0, A_MAX, 0);
    push_sample(4, A_MIN, 0, A_MIN, A_MAX, 0);
    push_sample(1, A_MAX, A_MIN, 0, A_MIN, 1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      reg_write(jitl_pkg::REG_PROP, random_lanes());
      reg_write(jitl_pkg::REG_DAMP, random_lanes());
      reg_write(jitl_pkg::REG_LIMIT, random_lanes());
      case ($urandom_range(0, 4))
        0: v = 0;
        1: v = $urandom_range(1, 64);
        2: v = $urandom_range(0, 1 << 16);
        3: v = 1 << 20;
        default: v = {$urandom, $urandom};
      endcase
      reg_write(jitl_pkg::REG_STEP, v);
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = jitl_pkg::FGAIN_ONE;
        2: v = $urandom_range(65537, 131071);
        3: v = $urandom_range(1, 512);
        default: v = $urandom_range(0, 65536);
      endcase
      reg_write(jitl_pkg::REG_FGAIN, v);
      quiet_send = (p == 1) || ($urandom_range(0, 3) == 0);
      quiet_recv = (p == 1) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) samples_to_send.push_back(random_sample());
      wait_idle();
    end

    if (mismatches == 0 && torque_cmd_due.size() == 0) begin
      $display("joint_impedance_torque_loop: match");
    end else begin
      $display("joint_impedance_torque_loop: mismatch");
    end
    $finish;
  end

endmodule
